@@ rtl/alist_pkg.sv @@
// ----------------------------------------------------------------------------
// alist_pkg: shared definitions for the array list unit
// Sizes, operation and status codes, and the command passed from the
// front end through the queue to the back end.
// ----------------------------------------------------------------------------
package alist_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int VALUE_W     = 32;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int FIDX_W      = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_FRONT  = 3'd1;
  localparam logic [OP_W-1:0] OP_SORTED = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [FIDX_W-1:0] NO_INDEX = '1;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_APPEND,
    CMD_FRONT,
    CMD_SORTED,
    CMD_REMOVE,
    CMD_FIND
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

endpackage

@@ rtl/array_list_insert_remove_find_unit.sv @@
// ----------------------------------------------------------------------------
// array_list_insert_remove_find_unit: ordered list of signed 32-bit values
// Append, full, unused op codes and empty-list searches need no memory walk; find
//   and remove walk up to the match, front insert walks the whole list, and sorted
//   insert first searches and then walks down from the top to its slot.
// The engine takes one item at a time while the queue holds later ones; results never stall.
// Reset: synchronous, active low; count and queue are cleared, entry memory is not.
// ----------------------------------------------------------------------------
//
// The front end accepts a transfer whenever the command queue has room and
// maps the op code to a command kind. The back end pops one command at a
// time. It owns the 64-entry memory (one write and one registered read per
// cycle) and the fill count. Searches walk upward with the read address one
// ahead of the compare. A sorted insert first searches for the first entry
// that is not less than the value, then a front or sorted insert opens
// its slot by walking down from the top, copying each entry one place up.
// A remove closes the gap by walking upward from the match. Every item
// ends in a single result strobe that carries the status, the matched
// index (or all ones) and the count after the operation.
module array_list_insert_remove_find_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [alist_pkg::OP_W-1:0]            in_op,
  input  logic signed [alist_pkg::VALUE_W-1:0]  in_value,
  output logic                                  out_valid,
  output logic [alist_pkg::STATUS_W-1:0]        out_status,
  output logic signed [alist_pkg::FIDX_W-1:0]   out_found_index,
  output logic [alist_pkg::IDX_W-1:0]           out_entry_count
);
  import alist_pkg::*;

  cmd_t  front_cmd;
  cmd_t  head_cmd;
  logic  q_push;
  logic  q_pop;
  logic  q_empty;
  logic  q_full;

  alist_front u_front (
    .start    (start),
    .busy     (busy),
    .in_op    (in_op),
    .in_value (in_value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (front_cmd)
  );

  alist_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  alist_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_entry_count (out_entry_count)
  );

endmodule

@@ rtl/alist_front.sv @@
// ----------------------------------------------------------------------------
// alist_front: command front end
// Takes operation transfers and turns the raw op code into a command kind
// for the queue.
// ----------------------------------------------------------------------------
module alist_front (
  input  logic                              start,
  output logic                              busy,
  input  logic [alist_pkg::OP_W-1:0]        in_op,
  input  logic signed [alist_pkg::VALUE_W-1:0] in_value,
  input  logic                              q_full,
  output logic                              q_push,
  output alist_pkg::cmd_t                   q_cmd
);
  import alist_pkg::*;

  assign busy   = q_full;
  assign q_push = start && !q_full;

  always_comb begin
    q_cmd.value = in_value;
    case (in_op)
      OP_APPEND: q_cmd.kind = CMD_APPEND;
      OP_FRONT:  q_cmd.kind = CMD_FRONT;
      OP_SORTED: q_cmd.kind = CMD_SORTED;
      OP_REMOVE: q_cmd.kind = CMD_REMOVE;
      OP_FIND:   q_cmd.kind = CMD_FIND;
      default:   q_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

@@ rtl/alist_queue.sv @@
// ----------------------------------------------------------------------------
// alist_queue: command queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module alist_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  alist_pkg::cmd_t push_cmd,
  input  logic            pop,
  output alist_pkg::cmd_t head_cmd,
  output logic            empty,
  output logic            full
);
  import alist_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == FULL_CNT);
  assign head_cmd = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/alist_back.sv @@
// ----------------------------------------------------------------------------
// alist_back: list engine
// Holds the entry memory and the count, and walks the memory one entry per
// cycle to search, open a slot or close a gap.
// ----------------------------------------------------------------------------
module alist_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_empty,
  input  alist_pkg::cmd_t                        q_cmd,
  output logic                                   q_pop,
  output logic                                   out_valid,
  output logic [alist_pkg::STATUS_W-1:0]         out_status,
  output logic signed [alist_pkg::FIDX_W-1:0]    out_found_index,
  output logic [alist_pkg::IDX_W-1:0]            out_entry_count
);
  import alist_pkg::*;

  localparam logic [IDX_W-1:0] FULL_LIMIT = IDX_W'(MAX_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPGO,
    S_UP,
    S_DN,
    S_FIN
  } state_t;

  state_t                   state_r, state_nxt;
  cmd_t                     cmd_r, cmd_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [IDX_W-1:0]         pos_r, pos_nxt;
  logic [IDX_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic [FIDX_W-1:0]        out_index_r;
  logic [IDX_W-1:0]         out_count_r;

  logic [VALUE_W-1:0]       mem [MAX_ENTRIES];
  logic [VALUE_W-1:0]       rd_data_r;
  logic [IDX_W-1:0]         rd_addr;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [VALUE_W-1:0]       mem_wdata;

  logic                     res_fire;
  logic [STATUS_W-1:0]      res_status;
  logic [FIDX_W-1:0]        res_index;
  logic                     is_full;
  logic                     scan_hit;
  logic                     scan_last;

  assign is_full   = (count_r >= FULL_LIMIT);
  assign scan_last = (IDX_W'(idx_r + 1'b1) == count_r);

  always_comb begin
    if (cmd_r.kind == CMD_SORTED) begin
      scan_hit = !($signed(rd_data_r) < cmd_r.value);
    end else begin
      scan_hit = (rd_data_r == cmd_r.value);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    rd_addr    = '0;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = rd_data_r;
    res_fire   = 1'b0;
    res_status = ST_DONE;
    res_index  = NO_INDEX;
    q_pop      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          idx_nxt = '0;
          case (q_cmd.kind)
            CMD_APPEND: begin
              res_fire = 1'b1;
              if (is_full) begin
                res_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r;
                mem_wdata = q_cmd.value;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_FRONT: begin
              if (is_full) begin
                res_fire   = 1'b1;
                res_status = ST_FULL;
              end else begin
                pos_nxt   = '0;
                state_nxt = S_UPGO;
              end
            end
            CMD_SORTED: begin
              if (is_full) begin
                res_fire   = 1'b1;
                res_status = ST_FULL;
              end else if (count_r == '0) begin
                pos_nxt   = '0;
                state_nxt = S_UPGO;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_REMOVE, CMD_FIND: begin
              if (count_r == '0) begin
                res_fire   = 1'b1;
                res_status = ST_NOT_FOUND;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_fire = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Read the next entry while the current one is compared.
        rd_addr = IDX_W'(idx_r + 1'b1);
        if (scan_hit) begin
          case (cmd_r.kind)
            CMD_SORTED: begin
              pos_nxt   = idx_r;
              state_nxt = S_UPGO;
            end
            CMD_REMOVE: begin
              pos_nxt = idx_r;
              if (scan_last) begin
                count_nxt  = count_r - 1'b1;
                res_fire   = 1'b1;
                res_index  = FIDX_W'(idx_r);
                state_nxt  = S_IDLE;
              end else begin
                state_nxt = S_DN;
              end
            end
            default: begin
              res_fire  = 1'b1;
              res_index = FIDX_W'(idx_r);
              state_nxt = S_IDLE;
            end
          endcase
        end else if (scan_last) begin
          if (cmd_r.kind == CMD_SORTED) begin
            pos_nxt   = count_r;
            state_nxt = S_UPGO;
          end else begin
            res_fire   = 1'b1;
            res_status = ST_NOT_FOUND;
            state_nxt  = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_DN: begin
        // Entry above moves down; the read runs two slots ahead of the write.
        rd_addr = IDX_W'(idx_r + 2'd2);
        mem_we  = 1'b1;
        if (IDX_W'(idx_r + 2'd2) == count_r) begin
          count_nxt = count_r - 1'b1;
          res_fire  = 1'b1;
          res_index = FIDX_W'(pos_r);
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_UPGO: begin
        if (pos_r == count_r) begin
          state_nxt = S_FIN;
        end else begin
          rd_addr   = count_r - 1'b1;
          idx_nxt   = count_r;
          state_nxt = S_UP;
        end
      end

      S_UP: begin
        // Entry below moves up; reads descend two slots ahead of the write.
        rd_addr = idx_r - 2'd2;
        mem_we  = 1'b1;
        if (IDX_W'(idx_r - 1'b1) == pos_r) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end

      S_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = cmd_r.value;
        count_nxt = count_r + 1'b1;
        res_fire  = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= res_fire;
    end
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    if (res_fire) begin
      out_status_r <= res_status;
      out_index_r  <= res_index;
      out_count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_index_r;
  assign out_entry_count = out_count_r;

endmodule

@@ tb/sv/alist_checker.sv @@
// ----------------------------------------------------------------------------
// alist_checker: result checker for the array list unit
// Watches the command and result channels, keeps its own copy of the list,
// and compares every result strobe with the oldest predicted reply.
// ----------------------------------------------------------------------------
module alist_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic [alist_pkg::OP_W-1:0]            in_op,
  input  logic signed [alist_pkg::VALUE_W-1:0]  in_value,
  input  logic                                  out_valid,
  input  logic [alist_pkg::STATUS_W-1:0]        out_status,
  input  logic signed [alist_pkg::FIDX_W-1:0]   out_found_index,
  input  logic [alist_pkg::IDX_W-1:0]           out_entry_count,
  output int                                    mismatches,
  output int                                    pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import alist_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [FIDX_W-1:0] found_index;
    logic [IDX_W-1:0]         entry_count;
  } reply_t;

  logic signed [VALUE_W-1:0] list_mem [MAX_ENTRIES];
  int                        list_len;
  reply_t                    expected_replies [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    list_len   = 0;
  end

  // Applies one command to the shadow list and returns the reply it earns.
  function automatic reply_t apply_list_op(input logic [OP_W-1:0] op,
                                           input logic signed [VALUE_W-1:0] v);
    reply_t r;
    int     pos;
    int     j;
    bit     hit;
    r.status      = ST_DONE;
    r.found_index = NO_INDEX;
    case (op)
      OP_APPEND, OP_FRONT, OP_SORTED: begin
        if (list_len >= MAX_ENTRIES - 1) begin
          r.status = ST_FULL;
        end else begin
          pos = (op == OP_APPEND) ? list_len : 0;
          if (op == OP_SORTED) begin
            while (pos < list_len && list_mem[pos] < v) pos++;
          end
          for (j = list_len; j > pos; j--) list_mem[j] = list_mem[j-1];
          list_mem[pos] = v;
          list_len++;
        end
      end
      OP_REMOVE, OP_FIND: begin
        pos = 0;
        hit = 1'b0;
        while (pos < list_len && !hit) begin
          if (list_mem[pos] == v) hit = 1'b1;
          else pos++;
        end
        if (!hit) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found_index = FIDX_W'(pos);
          if (op == OP_REMOVE) begin
            for (j = pos; j + 1 < list_len; j++) list_mem[j] = list_mem[j+1];
            list_len--;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = IDX_W'(list_len);
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      list_len = 0;
      expected_replies.delete();
    end else begin
      // Results first: a transfer at this edge cannot have its reply yet.
      if (out_valid) begin
        got = '{out_status, out_found_index, out_entry_count};
        if (expected_replies.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result status=%0d index=%0d count=%0d",
                     $realtime, got.status, got.found_index, got.entry_count);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (got.status != want.status || got.found_index != want.found_index ||
              got.entry_count != want.entry_count) begin
            if (mismatches < 10)
              $display("%0t: mismatch status %0d/%0d index %0d/%0d count %0d/%0d",
                       $realtime, want.status, got.status, want.found_index,
                       got.found_index, want.entry_count, got.entry_count);
            mismatches++;
          end
        end
      end
      if (start && !busy) expected_replies.push_back(apply_list_op(in_op, in_value));
    end
    pending = expected_replies.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for the array list unit
// Drives list commands through the start/busy handshake, first a directed
// sequence over the edge values and every operation, then random phases that
// alternately fill the list to full and drain it again. A checker module
// predicts and compares each result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import alist_pkg::*;

  // Every input starts at a known value, with reset asserted.
  logic                      clk      = 1'b0;
  logic                      rst_n    = 1'b0;
  logic                      start    = 1'b0;
  logic [OP_W-1:0]           in_op    = OP_APPEND;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      busy;
  logic                      out_valid;
  logic [STATUS_W-1:0]       out_status;
  logic signed [FIDX_W-1:0]  out_found_index;
  logic [IDX_W-1:0]          out_entry_count;
  int                        mismatches;
  int                        pending;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  // Number of op codes above the last defined one; the unit treats them as no-ops.
  localparam int UNUSED_OPS = (1 << OP_W) - 1 - int'(OP_FIND);

  array_list_insert_remove_find_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_entry_count (out_entry_count)
  );

  alist_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_entry_count (out_entry_count),
    .mismatches      (mismatches),
    .pending         (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Issues one command. A random idle gap may come first; start is only
  // lowered when there is a gap, so back-to-back transfers keep start high
  // without a second assignment in the same time step. The transfer happens
  // at the first rising edge that sees busy low.
  task automatic issue(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] v);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_op    <= op;
    in_value <= v;
    do @(posedge clk); while (busy);
  endtask

  // Mostly small values, so that finds and removes hit stored entries and
  // sorted inserts meet equal values; now and then a full-width value.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    if ($urandom_range(0, 9) < 7) begin
      v = $urandom_range(0, 15);
      v = v - 8;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // A filling phase is mostly inserts, so the list runs into the full limit
  // and stays there for a while; a draining phase is mostly removes.
  function automatic logic [OP_W-1:0] pick_op(input bit filling);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return OP_FIND + OP_W'($urandom_range(1, UNUSED_OPS));
    if (filling) begin
      if (roll < 85) return OP_APPEND + OP_W'($urandom_range(0, 2));
      if (roll < 95) return OP_FIND;
      return OP_REMOVE;
    end
    if (roll < 20) return OP_APPEND + OP_W'($urandom_range(0, 2));
    if (roll < 35) return OP_FIND;
    return OP_REMOVE;
  endfunction

  initial begin
    int phase_len [6];
    phase_len = '{100, 70, 100, 70, 100, 60};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Searches of the empty list find nothing.
    issue(OP_FIND, 32'sd5);
    issue(OP_REMOVE, 32'sd5);
    // Extremes of the value field at both ends of the list.
    issue(OP_APPEND, VAL_MIN);
    issue(OP_APPEND, VAL_MAX);
    issue(OP_FRONT, -32'sd1);
    issue(OP_FRONT, 32'sd0);
    issue(OP_FIND, VAL_MIN);
    // Removes, each taking the first entry, empty the list again.
    issue(OP_REMOVE, 32'sd0);
    issue(OP_REMOVE, -32'sd1);
    issue(OP_REMOVE, VAL_MIN);
    issue(OP_REMOVE, VAL_MAX);
    // Sorted inserts, including an equal value that must land before its twin.
    issue(OP_SORTED, 32'sd10);
    issue(OP_SORTED, -32'sd10);
    issue(OP_SORTED, 32'sd10);
    issue(OP_SORTED, VAL_MIN);
    issue(OP_SORTED, VAL_MAX);
    issue(OP_SORTED, 32'sd0);
    issue(OP_FIND, 32'sd10);
    issue(OP_FIND, 32'sd12345);
    issue(OP_REMOVE, 32'sd10);
    issue(OP_REMOVE, VAL_MAX);
    // The unused op codes leave the list alone.
    for (int k = 1; k <= UNUSED_OPS; k++) issue(OP_FIND + OP_W'(k), $urandom);

    // Random phases: fill, drain, and again.
    foreach (phase_len[p]) begin
      for (int k = 0; k < phase_len[p]; k++) issue(pick_op(p % 2 == 0), pick_value());
    end
    start <= 1'b0;

    // Wait for the last replies, then long enough for a full-list shift to
    // show any stray strobe. Sampling on the falling edge keeps this clear
    // of the checker's updates.
    do @(negedge clk); while (pending != 0);
    repeat (200) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("array_list_insert_remove_find_unit test passed");
    end else begin
      $display("array_list_insert_remove_find_unit test failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run: about 525 items, each an idle gap plus at
  // worst a sorted insert into a nearly full list, take near 0.8 ms.
  initial begin
    #20_000_000;
    $display("array_list_insert_remove_find_unit test failed");
    $finish;
  end

endmodule
